// ----- sv/uer_pkg.sv -----
`timescale 1ns / 1ps

package uer_pkg;

    // Measurement sequencer phases.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_TLOW  = 3'd1;
    localparam logic [2:0] PH_THIGH = 3'd2;
    localparam logic [2:0] PH_WAIT  = 3'd3;
    localparam logic [2:0] PH_ECHO  = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_INTERVAL = 2'd0;
    localparam logic [1:0] REG_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_SPEED    = 2'd2;

    localparam logic [23:0] INTERVAL_RESET = 24'd100000;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd20000;
    localparam logic [15:0] SPEED_RESET    = 16'd2248;

    localparam logic [15:0] TRIG_LOW_TICKS  = 16'd2;
    localparam logic [15:0] TRIG_HIGH_TICKS = 16'd10;
    localparam logic [8:0]  NO_ECHO         = 9'd401;
    localparam logic [8:0]  MAX_DIST        = 9'd400;
    localparam logic [23:0] SINCE_MAX       = 24'hFFFFFF;

    typedef struct packed {
        logic       trigger_level;
        logic [8:0] distance_cm;
        logic       new_measure;
        logic       busy_res;
    } result_t;

endpackage

// ----- sv/ultrasonic_echo_ranger_unit.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     echo_level
// out       output     out_valid / out_ready   trigger_level, distance_cm, new_measure, busy_res
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each tick transaction is processed in the cycle it is accepted; its result is
// registered and appears on the out channel, so one transaction per cycle is sustained
// while out_ready is high. The sequencer state update and the 16x16 distance multiply
// form the single combinational stage. A two-entry output buffer lets
// one more transaction in while a result is stalled; in_ready drops only when
// both entries are full. Reset restores the register defaults and the idle phase.
module ultrasonic_echo_ranger_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        echo_level,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        trigger_level,
    output logic [8:0]  distance_cm,
    output logic        new_measure,
    output logic        busy_res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import uer_pkg::*;

    logic [23:0] interval_reg;
    logic [15:0] timeout_reg;
    logic [15:0] speed_reg;

    logic [2:0]  phase_reg,         phase_next;
    logic [15:0] phase_count_reg,   phase_count_next;
    logic [23:0] since_good_reg,    since_good_next;
    logic [8:0]  last_distance_reg, last_distance_next;

    result_t     res_next;
    result_t     out_data_reg;
    result_t     skid_data_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;

    logic        accept;
    logic [31:0] product;
    logic [14:0] dist_full;
    logic [8:0]  dist_sat;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RESET;
            timeout_reg  <= TIMEOUT_RESET;
            speed_reg    <= SPEED_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_INTERVAL: interval_reg <= cfg_data;
                REG_TIMEOUT:  timeout_reg  <= cfg_data[15:0];
                REG_SPEED:    speed_reg    <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    // Width in ticks times speed in Q16, halved and truncated to centimeters.
    assign product   = {16'd0, phase_count_reg} * {16'd0, speed_reg};
    assign dist_full = product[31:17];
    assign dist_sat  = (dist_full > {6'd0, MAX_DIST}) ? MAX_DIST : dist_full[8:0];

    always_comb
    begin
        phase_next         = phase_reg;
        phase_count_next   = phase_count_reg;
        last_distance_next = last_distance_reg;
        since_good_next    = (since_good_reg < SINCE_MAX) ? since_good_reg + 24'd1
                                                          : since_good_reg;
        res_next.trigger_level = 1'b0;
        res_next.new_measure   = 1'b0;
        res_next.busy_res      = (phase_reg != PH_IDLE);

        case (phase_reg)
            PH_TLOW:
            begin
                phase_count_next = phase_count_reg + 16'd1;
                if (phase_count_next >= TRIG_LOW_TICKS)
                begin
                    phase_next       = PH_THIGH;
                    phase_count_next = 16'd0;
                end
            end
            PH_THIGH:
            begin
                res_next.trigger_level = 1'b1;
                phase_count_next = phase_count_reg + 16'd1;
                if (phase_count_next >= TRIG_HIGH_TICKS)
                begin
                    phase_next       = PH_WAIT;
                    phase_count_next = 16'd0;
                end
            end
            PH_WAIT:
            begin
                if (echo_level)
                begin
                    phase_next       = PH_ECHO;
                    phase_count_next = 16'd1;
                end
                else if (phase_count_reg >= timeout_reg)
                begin
                    last_distance_next   = NO_ECHO;
                    res_next.new_measure = 1'b1;
                    phase_next           = PH_IDLE;
                    phase_count_next     = 16'd0;
                end
                else
                begin
                    phase_count_next = phase_count_reg + 16'd1;
                end
            end
            PH_ECHO:
            begin
                if (!echo_level)
                begin
                    last_distance_next   = dist_sat;
                    since_good_next      = 24'd0;
                    res_next.new_measure = 1'b1;
                    phase_next           = PH_IDLE;
                    phase_count_next     = 16'd0;
                end
                else if (phase_count_reg >= timeout_reg)
                begin
                    last_distance_next   = NO_ECHO;
                    res_next.new_measure = 1'b1;
                    phase_next           = PH_IDLE;
                    phase_count_next     = 16'd0;
                end
                else
                begin
                    phase_count_next = phase_count_reg + 16'd1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (since_good_next > interval_reg)
                begin
                    phase_next       = PH_TLOW;
                    phase_count_next = 16'd0;
                end
            end
        endcase

        res_next.distance_cm = last_distance_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            phase_count_reg   <= 16'd0;
            since_good_reg    <= 24'd0;
            last_distance_reg <= 9'd0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            phase_count_reg   <= phase_count_next;
            since_good_reg    <= since_good_next;
            last_distance_reg <= last_distance_next;
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (accept)
                out_data_reg <= res_next;
        end
        else if (accept)
        begin
            skid_data_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign trigger_level = out_data_reg.trigger_level;
    assign distance_cm   = out_data_reg.distance_cm;
    assign new_measure   = out_data_reg.new_measure;
    assign busy_res      = out_data_reg.busy_res;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output register empty");

    a_done_is_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && new_measure |-> busy_res)
        else $error("measurement completed outside a busy phase");

    a_trig_is_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && trigger_level |-> busy_res && !new_measure)
        else $error("trigger driven outside the trigger phase");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> distance_cm <= NO_ECHO)
        else $error("distance out of range");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TLOW || phase_reg == PH_THIGH) |-> phase_count_reg < TRIG_HIGH_TICKS)
        else $error("trigger phase counter overran");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import uer_pkg::*;

    localparam int         CYCLE_LIMIT  = 600000;
    localparam int         RANDOM_TICKS = 560;
    localparam int         SHAPE_SPAN   = 40;
    localparam int         REPORT_MAX   = 10;
    localparam logic [1:0] REG_UNUSED   = 2'd3;

    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] count;
        logic [23:0] since_good;
        logic [8:0]  last_cm;
    } ranger_state_t;

    typedef struct packed {
        logic [23:0] interval;
        logic [15:0] timeout;
        logic [15:0] speed;
    } ranger_cfg_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        echo_level = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        trigger_level;
    logic [8:0]  distance_cm;
    logic        new_measure;
    logic        busy_res;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [23:0] cfg_data = 24'd0;

    ultrasonic_echo_ranger_unit u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .echo_level    (echo_level),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .trigger_level (trigger_level),
        .distance_cm   (distance_cm),
        .new_measure   (new_measure),
        .busy_res      (busy_res),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // Echo samples waiting to be sent and ranger outputs still owed by the block.
    logic          tick_q[$];
    result_t       pending_results[$];

    ranger_cfg_t   reg_cfg;
    ranger_state_t check_state;
    ranger_state_t plan_state;

    int            script_delay[$];
    int            script_width[$];
    int            wait_delay;
    int            echo_width;
    bit            shape_noisy;
    bit            steady;

    int            in_gap;
    int            out_gap;
    int            cycle_count;
    int            mismatches;
    int            unexpected;
    int            ticks_checked;
    int            echo_hits;
    int            echo_misses;
    int            reg_writes;
    int            phase_no;

    // One microsecond tick of the ranging sequencer.
    function automatic result_t ranger_tick(inout ranger_state_t st, input ranger_cfg_t c,
                                            input logic echo);
        result_t     r;
        logic [31:0] prod;
        r.trigger_level = 1'b0;
        r.new_measure   = 1'b0;
        r.busy_res      = (st.phase != PH_IDLE);
        if (st.since_good < SINCE_MAX)
        begin
            st.since_good = st.since_good + 24'd1;
        end
        case (st.phase)
            PH_TLOW:
            begin
                st.count = st.count + 16'd1;
                if (st.count >= TRIG_LOW_TICKS)
                begin
                    st.phase = PH_THIGH;
                    st.count = 16'd0;
                end
            end
            PH_THIGH:
            begin
                r.trigger_level = 1'b1;
                st.count = st.count + 16'd1;
                if (st.count >= TRIG_HIGH_TICKS)
                begin
                    st.phase = PH_WAIT;
                    st.count = 16'd0;
                end
            end
            PH_WAIT:
            begin
                if (echo)
                begin
                    st.phase = PH_ECHO;
                    st.count = 16'd1;
                end
                else if (st.count >= c.timeout)
                begin
                    st.last_cm = NO_ECHO;
                    r.new_measure = 1'b1;
                    st.phase = PH_IDLE;
                    st.count = 16'd0;
                end
                else
                begin
                    st.count = st.count + 16'd1;
                end
            end
            PH_ECHO:
            begin
                if (!echo)
                begin
                    prod = ({16'd0, st.count} * {16'd0, c.speed}) >> 17;
                    st.last_cm = (prod > 32'(MAX_DIST)) ? MAX_DIST : prod[8:0];
                    st.since_good = 24'd0;
                    r.new_measure = 1'b1;
                    st.phase = PH_IDLE;
                    st.count = 16'd0;
                end
                else if (st.count >= c.timeout)
                begin
                    st.last_cm = NO_ECHO;
                    r.new_measure = 1'b1;
                    st.phase = PH_IDLE;
                    st.count = 16'd0;
                end
                else
                begin
                    st.count = st.count + 16'd1;
                end
            end
            default:
            begin
                st.phase = PH_IDLE;
                if (st.since_good > c.interval)
                begin
                    st.phase = PH_TLOW;
                    st.count = 16'd0;
                end
            end
        endcase
        r.distance_cm = st.last_cm;
        return r;
    endfunction

    function automatic int pick_gap(input bit calm);
        int roll;
        roll = $urandom_range(99);
        if (calm || roll < 50)
        begin
            return 0;
        end
        else if (roll < 85)
        begin
            return $urandom_range(3, 1);
        end
        else if (roll < 97)
        begin
            return $urandom_range(10, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    // Decides how the echo behaves for the measurement that has just started waiting.
    task automatic pick_echo_shape;
        int roll;
        int span;
        int good_max;
        span = (reg_cfg.timeout > SHAPE_SPAN) ? SHAPE_SPAN : int'(reg_cfg.timeout);
        good_max = (span < 1) ? 1 : span;
        roll = $urandom_range(99);
        shape_noisy = 1'b0;
        if (script_delay.size() > 0)
        begin
            wait_delay = script_delay.pop_front();
            echo_width = script_width.pop_front();
        end
        else if (roll >= 90)
        begin
            shape_noisy = 1'b1;
        end
        else if (roll >= 75 && reg_cfg.timeout <= SHAPE_SPAN)
        begin
            // Echo stays high past the allowed width.
            wait_delay = $urandom_range(span, 0);
            echo_width = good_max + 1;
        end
        else if (roll >= 60 && reg_cfg.timeout <= SHAPE_SPAN)
        begin
            // Echo never rises in time.
            wait_delay = span + 1;
            echo_width = 1;
        end
        else
        begin
            wait_delay = $urandom_range(span, 0);
            echo_width = $urandom_range(good_max, 1);
        end
    endtask

    // Builds echo samples that answer the trigger the block is about to give.
    task automatic plan_ticks(input int n);
        logic       echo;
        logic [2:0] prev;
        result_t    unused_result;
        for (int i = 0; i < n; i++)
        begin
            case (plan_state.phase)
                PH_WAIT:
                begin
                    echo = shape_noisy ? 1'($urandom_range(1))
                                       : (int'(plan_state.count) >= wait_delay);
                end
                PH_ECHO:
                begin
                    echo = shape_noisy ? 1'($urandom_range(1))
                                       : (int'(plan_state.count) < echo_width);
                end
                default:
                begin
                    echo = 1'($urandom_range(1));
                end
            endcase
            tick_q.push_back(echo);
            prev = plan_state.phase;
            unused_result = ranger_tick(plan_state, reg_cfg, echo);
            if (prev != PH_WAIT && plan_state.phase == PH_WAIT)
            begin
                pick_echo_shape();
            end
        end
    endtask

    function automatic void apply_reg(input logic [1:0] idx, input logic [23:0] data);
        case (idx)
            REG_INTERVAL: reg_cfg.interval = data;
            REG_TIMEOUT:  reg_cfg.timeout = data[15:0];
            REG_SPEED:    reg_cfg.speed = data[15:0];
            default:      ;
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(idx, data);
        reg_writes++;
    endtask

    task automatic wait_drained;
        while (tick_q.size() != 0 || in_valid || pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Tick driver: every accepted transaction advances the checking copy of the sequencer.
    always @(posedge clk or negedge rst_n)
    begin
        bit slot_taken;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            echo_level <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            slot_taken = in_valid;
            if (in_valid && in_ready)
            begin
                pending_results.push_back(ranger_tick(check_state, reg_cfg, echo_level));
                slot_taken = 1'b0;
            end
            if (!slot_taken)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (tick_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    echo_level <= tick_q.pop_front();
                    in_gap = pick_gap(steady);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.trigger_level = trigger_level;
                got.distance_cm = distance_cm;
                got.new_measure = new_measure;
                got.busy_res = busy_res;
                if (pending_results.size() == 0)
                begin
                    unexpected++;
                    if (mismatches + unexpected <= REPORT_MAX)
                    begin
                        $display("Unexpected result: trig %0d dist %0d new %0d busy %0d",
                                 got.trigger_level, got.distance_cm, got.new_measure,
                                 got.busy_res);
                    end
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (want.new_measure)
                    begin
                        if (want.distance_cm == NO_ECHO)
                        begin
                            echo_misses++;
                        end
                        else
                        begin
                            echo_hits++;
                        end
                    end
                    if (got.trigger_level !== want.trigger_level
                        || got.distance_cm !== want.distance_cm
                        || got.new_measure !== want.new_measure
                        || got.busy_res !== want.busy_res)
                    begin
                        mismatches++;
                        if (mismatches + unexpected <= REPORT_MAX)
                        begin
                            $display("Tick %0d expected: trig %0d dist %0d new %0d busy %0d",
                                     ticks_checked, want.trigger_level, want.distance_cm,
                                     want.new_measure, want.busy_res);
                            $display("Tick %0d got:      trig %0d dist %0d new %0d busy %0d",
                                     ticks_checked, got.trigger_level, got.distance_cm,
                                     got.new_measure, got.busy_res);
                        end
                    end
                    ticks_checked++;
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                out_gap = pick_gap(steady);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int          random_ticks;
        int          n;
        int          roll;
        int          width;
        logic [23:0] interval_val;
        logic [15:0] timeout_val;
        logic [15:0] speed_val;

        reg_cfg.interval = INTERVAL_RESET;
        reg_cfg.timeout = TIMEOUT_RESET;
        reg_cfg.speed = SPEED_RESET;
        check_state = '0;
        check_state.phase = PH_IDLE;
        plan_state = check_state;
        steady = 1'b0;
        random_ticks = 0;
        phase_no = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: the long default interval keeps the block idle.
        plan_ticks(2);
        wait_drained();

        // Zero timeout at full speed: a one-tick echo gives zero distance, then a missing
        // echo times out on the first waiting tick.
        write_reg(REG_INTERVAL, 24'd0);
        write_reg(REG_TIMEOUT, 24'd0);
        write_reg(REG_SPEED, 24'h00FFFF);
        script_delay.push_back(0);
        script_width.push_back(1);
        script_delay.push_back(1);
        script_width.push_back(1);
        plan_ticks(29);
        wait_drained();

        // One long echo at full speed runs past the largest distance and saturates.
        write_reg(REG_TIMEOUT, 24'h00FFFF);
        write_reg(REG_INTERVAL, 24'd3);
        width = $urandom_range(830, 805);
        script_delay.push_back(2);
        script_width.push_back(width);
        plan_ticks(width + 24);
        wait_drained();

        while (random_ticks < RANDOM_TICKS)
        begin
            phase_no++;
            roll = $urandom_range(99);
            if (phase_no == 1 || roll < 8)
            begin
                interval_val = SINCE_MAX;
            end
            else if (roll < 35)
            begin
                interval_val = 24'd0;
            end
            else
            begin
                interval_val = 24'($urandom_range(40, 1));
            end
            roll = $urandom_range(99);
            if (roll < 15)
            begin
                timeout_val = 16'd0;
            end
            else if (roll < 25)
            begin
                timeout_val = 16'd1;
            end
            else if (roll < 30)
            begin
                timeout_val = 16'hFFFF;
            end
            else
            begin
                timeout_val = 16'($urandom_range(SHAPE_SPAN, 2));
            end
            roll = $urandom_range(99);
            if (phase_no == 2 || roll < 15)
            begin
                speed_val = 16'd0;
            end
            else if (roll < 30)
            begin
                speed_val = 16'hFFFF;
            end
            else
            begin
                speed_val = 16'($urandom);
            end
            if (phase_no <= 2 || $urandom_range(9) < 7)
            begin
                write_reg(REG_INTERVAL, interval_val);
            end
            // The upper bits of the data word are don't-care for the 16-bit registers.
            if ($urandom_range(9) < 7)
            begin
                write_reg(REG_TIMEOUT, {8'($urandom), timeout_val});
            end
            if (phase_no <= 2 || $urandom_range(9) < 7)
            begin
                write_reg(REG_SPEED, {8'($urandom), speed_val});
            end
            if ($urandom_range(9) == 0)
            begin
                write_reg(REG_UNUSED, 24'($urandom));
            end
            steady = ($urandom_range(3) == 0);
            n = $urandom_range(160, 40);
            plan_ticks(n);
            random_ticks += n;
            wait_drained();
        end

        steady = 1'b0;
        repeat (8) @(posedge clk);

        $display("Checked %0d tick transactions over %0d random phases and %0d register writes.",
                 ticks_checked, phase_no, reg_writes);
        $display("Measurements finished: %0d with an echo, %0d without.",
                 echo_hits, echo_misses);
        if (mismatches == 0 && unexpected == 0 && pending_results.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("%0d mismatches, %0d unexpected results, %0d results missing.",
                     mismatches, unexpected, pending_results.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/uer_pkg.sv
sv/ultrasonic_echo_ranger_unit.sv
tb/tb_top.sv
